FILE: src/brpd_pkg.sv
package brpd_pkg;

  // Page geometry. The address register carries one extra sign bit so that
  // it can step below zero at the end of a page.
  localparam int PAGE_BYTES = 32768;
  localparam int ADDR_W     = $clog2(PAGE_BYTES) + 1;

  // Fixed field widths of the result.
  localparam int BYTE_W  = 8;
  localparam int WADDR_W = 15;
  localparam int COUNT_W = 16;

  // Header decode: bit 7 marks a run, run length is 258 - header.
  localparam int       RUN_FLAG_BIT = 7;
  localparam logic [8:0] RUN_BIAS   = 9'd258;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic               write_enable;
    logic [WADDR_W-1:0] write_address;
    logic [BYTE_W-1:0]  byte_value;
    logic [BYTE_W-1:0]  repeat_count;
    logic               page_done;
    logic [COUNT_W-1:0] bytes_used;
  } brpd_result_t;

endpackage

FILE: src/brpd_in_reg.sv
// Input register: holds one stream byte until the decode stage takes it.
module brpd_in_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [brpd_pkg::BYTE_W-1:0]  code_byte,
  input  logic                         take,
  output logic                         held_valid,
  output logic [brpd_pkg::BYTE_W-1:0]  held_byte
);

  logic                        valid;
  logic [brpd_pkg::BYTE_W-1:0] data;

  assign in_ready   = !valid || take;
  assign held_valid = valid;
  assign held_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= code_byte;
    end
  end

endmodule

FILE: src/brpd_core.sv
// Decode state and the per-byte update. State advances only on take.
module brpd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [brpd_pkg::BYTE_W-1:0]   code_byte,
  output brpd_pkg::brpd_result_t        result
);

  typedef enum logic [1:0] {
    MODE_HEADER    = 2'd0,
    MODE_RUN_VALUE = 2'd1,
    MODE_LITERAL   = 2'd2
  } mode_t;

  localparam int AW = brpd_pkg::ADDR_W;
  localparam logic signed [AW-1:0] TOP_ADDR = AW'(brpd_pkg::PAGE_BYTES - 1);

  mode_t                            mode, mode_next;
  logic [brpd_pkg::BYTE_W-1:0]      pending_count, pending_count_next;
  logic signed [AW-1:0]             next_address, next_address_next;
  logic [brpd_pkg::COUNT_W-1:0]     consumed_count, consumed_count_next;
  logic [brpd_pkg::BYTE_W-1:0]      run_length, run_length_next;

  logic                             block_end;
  logic [AW-1:0]                    room;
  logic signed [AW-1:0]             addr_after;
  logic [brpd_pkg::COUNT_W-1:0]     count_inc;

  always_comb begin
    result     = '0;
    block_end  = 1'b0;
    room       = $unsigned(next_address) + AW'(1);
    addr_after = next_address;
    count_inc  = (consumed_count != brpd_pkg::COUNT_MAX) ?
                 consumed_count + brpd_pkg::COUNT_W'(1) : consumed_count;

    mode_next          = mode;
    pending_count_next = pending_count;
    run_length_next    = run_length;

    unique case (mode)
      MODE_RUN_VALUE: begin
        if (!next_address[AW-1]) begin
          result.write_enable  = 1'b1;
          result.write_address = brpd_pkg::WADDR_W'($unsigned(next_address));
          result.byte_value    = code_byte;
          // clip the run at address zero
          if (AW'(run_length) > room) begin
            result.repeat_count = room[brpd_pkg::BYTE_W-1:0];
          end else begin
            result.repeat_count = run_length;
          end
        end
        addr_after = next_address - $signed(AW'(run_length));
        mode_next  = MODE_HEADER;
        block_end  = 1'b1;
      end
      MODE_LITERAL: begin
        if (!next_address[AW-1]) begin
          result.write_enable  = 1'b1;
          result.write_address = brpd_pkg::WADDR_W'($unsigned(next_address));
          result.byte_value    = code_byte;
          result.repeat_count  = brpd_pkg::BYTE_W'(1);
        end
        addr_after = next_address - AW'(1);
        if (pending_count <= brpd_pkg::BYTE_W'(1)) begin
          pending_count_next = '0;
          mode_next          = MODE_HEADER;
          block_end          = 1'b1;
        end else begin
          pending_count_next = pending_count - brpd_pkg::BYTE_W'(1);
        end
      end
      default: begin
        if (code_byte[brpd_pkg::RUN_FLAG_BIT]) begin
          run_length_next = brpd_pkg::BYTE_W'(brpd_pkg::RUN_BIAS - {1'b0, code_byte});
          mode_next       = MODE_RUN_VALUE;
        end else begin
          pending_count_next = code_byte + brpd_pkg::BYTE_W'(1);
          mode_next          = MODE_LITERAL;
        end
      end
    endcase

    next_address_next   = addr_after;
    consumed_count_next = count_inc;

    // page complete: report and rearm
    if (block_end && addr_after[AW-1]) begin
      result.page_done    = 1'b1;
      result.bytes_used   = count_inc;
      mode_next           = MODE_HEADER;
      pending_count_next  = '0;
      next_address_next   = TOP_ADDR;
      consumed_count_next = '0;
      run_length_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_HEADER;
      pending_count  <= '0;
      next_address   <= TOP_ADDR;
      consumed_count <= '0;
      run_length     <= '0;
    end else if (take) begin
      mode           <= mode_next;
      pending_count  <= pending_count_next;
      next_address   <= next_address_next;
      consumed_count <= consumed_count_next;
      run_length     <= run_length_next;
    end
  end

endmodule

FILE: src/brpd_out_reg.sv
// Result register: loads on take, holds until the consumer accepts.
module brpd_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  brpd_pkg::brpd_result_t result_in,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output brpd_pkg::brpd_result_t result_out
);

  logic                   valid;
  brpd_pkg::brpd_result_t data;

  assign free       = !valid || out_ready;
  assign out_valid  = valid;
  assign result_out = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data <= result_in;
    end
  end

endmodule

FILE: src/backward_rle_page_decoder.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | code_byte
// out      | out_valid / out_ready| write_enable, write_address, byte_value,
//          |                      | repeat_count, page_done, bytes_used
//
// One result per request, through input register, decode logic and result
// register; a byte leaves the input register when the result register is
// free. Sustained rate is one byte per cycle while out_ready stays high;
// the decode state updates as the byte moves on to the result register.
// Reset (rst, synchronous) empties both registers and rearms the decoder.
// A stalled output holds its result; the input register takes one more request.
module backward_rle_page_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [brpd_pkg::BYTE_W-1:0]     code_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            write_enable,
  output logic [brpd_pkg::WADDR_W-1:0]    write_address,
  output logic [brpd_pkg::BYTE_W-1:0]     byte_value,
  output logic [brpd_pkg::BYTE_W-1:0]     repeat_count,
  output logic                            page_done,
  output logic [brpd_pkg::COUNT_W-1:0]    bytes_used
);

  logic                        held_valid;
  logic [brpd_pkg::BYTE_W-1:0] held_byte;
  logic                        out_free;
  logic                        take;
  brpd_pkg::brpd_result_t      decoded;
  brpd_pkg::brpd_result_t      result;

  // byte moves into decode when the result register can take it
  assign take = held_valid && out_free;

  brpd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_byte  (code_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  brpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .code_byte (held_byte),
    .result    (decoded)
  );

  brpd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .result_in  (decoded),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result)
  );

  assign write_enable  = result.write_enable;
  assign write_address = result.write_address;
  assign byte_value    = result.byte_value;
  assign repeat_count  = result.repeat_count;
  assign page_done     = result.page_done;
  assign bytes_used    = result.bytes_used;

endmodule

FILE: src/brpd_checker.sv
module brpd_port_asserts (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            write_enable,
  input logic [brpd_pkg::WADDR_W-1:0]    write_address,
  input logic [brpd_pkg::BYTE_W-1:0]     byte_value,
  input logic [brpd_pkg::BYTE_W-1:0]     repeat_count,
  input logic                            page_done,
  input logic [brpd_pkg::COUNT_W-1:0]    bytes_used
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_address)
      && $stable(repeat_count) && $stable(bytes_used))
    else $error("stalled result changed");

  // no-write results carry zero write fields
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |->
      write_address == '0 && byte_value == '0 && repeat_count == '0)
    else $error("write fields set without write");

  // a write covers 1..130 addresses and never passes address zero
  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |->
      repeat_count != '0 && repeat_count <= 8'd130
      && {8'd0, repeat_count} <= {1'b0, write_address} + 16'd1)
    else $error("bad write span");

  // count only reported at page end, and then nonzero
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (page_done ? bytes_used != '0 : bytes_used == '0))
    else $error("bytes_used mismatch with page_done");

endmodule

bind backward_rle_page_decoder brpd_port_asserts u_brpd_port_asserts (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .write_enable  (write_enable),
  .write_address (write_address),
  .byte_value    (byte_value),
  .repeat_count  (repeat_count),
  .page_done     (page_done),
  .bytes_used    (bytes_used)
);

FILE: test/brpd_checker.sv
`timescale 1ns / 1ps

module brpd_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [brpd_pkg::BYTE_W-1:0]  code_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         write_enable,
  input  logic [brpd_pkg::WADDR_W-1:0] write_address,
  input  logic [brpd_pkg::BYTE_W-1:0]  byte_value,
  input  logic [brpd_pkg::BYTE_W-1:0]  repeat_count,
  input  logic                         page_done,
  input  logic [brpd_pkg::COUNT_W-1:0] bytes_used,
  output int                           fail_count,
  output int                           pending_results
);

  localparam int AW         = brpd_pkg::ADDR_W;
  localparam int PRINT_CAP  = 100;

  typedef enum logic [1:0] {
    WAIT_HEADER,
    WAIT_RUN_BYTE,
    IN_LITERALS
  } decode_state_t;

  // Decoder image
  decode_state_t                  state;
  logic [7:0]                     literals_left;
  logic signed [AW-1:0]           next_addr;
  logic [brpd_pkg::COUNT_W-1:0]   used_ctr;
  logic [7:0]                     run_len;

  brpd_pkg::brpd_result_t expected_writes [$];
  brpd_pkg::brpd_result_t want;
  brpd_pkg::brpd_result_t got;
  int errors      = 0;
  int results_idx = 0;

  function automatic void rearm_page();
    state         = WAIT_HEADER;
    literals_left = '0;
    next_addr     = AW'(brpd_pkg::PAGE_BYTES - 1);
    used_ctr      = '0;
    run_len       = '0;
  endfunction

  // One stream byte in, one result out; only run values and literals write.
  function automatic brpd_pkg::brpd_result_t decode_byte(input logic [7:0] b);
    brpd_pkg::brpd_result_t r;
    logic                   block_end;
    int                     room;
    logic [7:0]             take;
    r         = '0;
    block_end = 1'b0;
    if (used_ctr != brpd_pkg::COUNT_MAX) used_ctr = used_ctr + 1'b1;

    case (state)
      WAIT_RUN_BYTE: begin
        take = run_len;
        if (!next_addr[AW-1]) begin
          room = int'(next_addr) + 1;
          if (int'(run_len) > room) take = 8'(room);   // clip at address 0
          r.write_enable  = 1'b1;
          r.write_address = next_addr[brpd_pkg::WADDR_W-1:0];
          r.byte_value    = b;
          r.repeat_count  = take;
        end
        next_addr = next_addr - $signed({1'b0, run_len});
        state     = WAIT_HEADER;
        block_end = 1'b1;
      end
      IN_LITERALS: begin
        if (!next_addr[AW-1]) begin
          r.write_enable  = 1'b1;
          r.write_address = next_addr[brpd_pkg::WADDR_W-1:0];
          r.byte_value    = b;
          r.repeat_count  = 8'd1;
        end
        next_addr = next_addr - AW'(1);
        if (literals_left <= 8'd1) begin
          literals_left = '0;
          state         = WAIT_HEADER;
          block_end     = 1'b1;
        end else begin
          literals_left = literals_left - 1'b1;
        end
      end
      default: begin
        if (b[brpd_pkg::RUN_FLAG_BIT]) begin
          run_len = 8'(brpd_pkg::RUN_BIAS - {1'b0, b});
          state   = WAIT_RUN_BYTE;
        end else begin
          literals_left = b + 8'd1;
          state         = IN_LITERALS;
        end
      end
    endcase

    // page closes only on a block boundary once the address went negative
    if (block_end && next_addr[AW-1]) begin
      r.page_done  = 1'b1;
      r.bytes_used = used_ctr;
      rearm_page();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int seen, input int wanted);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] result %0d: %s got %0d, expected %0d",
               $time, results_idx, what, seen, wanted);
    else if (errors == PRINT_CAP + 1)
      $display("[%0t] further mismatches counted but not printed", $time);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rearm_page();
      expected_writes.delete();
    end else begin
      // retire first: a result can never belong to the request taken this edge
      if (out_valid && out_ready) begin
        got = '{write_enable, write_address, byte_value, repeat_count,
                page_done, bytes_used};
        if (expected_writes.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = expected_writes.pop_front();
          if (got.write_enable !== want.write_enable)
            report_mismatch("write_enable", got.write_enable, want.write_enable);
          if (got.write_address !== want.write_address)
            report_mismatch("write_address", got.write_address, want.write_address);
          if (got.byte_value !== want.byte_value)
            report_mismatch("byte_value", got.byte_value, want.byte_value);
          if (got.repeat_count !== want.repeat_count)
            report_mismatch("repeat_count", got.repeat_count, want.repeat_count);
          if (got.page_done !== want.page_done)
            report_mismatch("page_done", got.page_done, want.page_done);
          if (got.bytes_used !== want.bytes_used)
            report_mismatch("bytes_used", got.bytes_used, want.bytes_used);
        end
        results_idx++;
      end
      if (in_valid && in_ready) expected_writes.push_back(decode_byte(code_byte));
    end
    pending_results <= expected_writes.size();
    fail_count      <= errors;
  end

endmodule

FILE: test/backward_rle_page_decoder_tb.sv
`timescale 1ns / 1ps

module backward_rle_page_decoder_tb;

  // Run length knobs
  localparam int CYCLE_LIMIT   = 200_000;    // slowest legal run is well under this
  localparam int RANDOM_TARGET = 300;        // stream bytes in the random phase
  localparam int TAIL_CAP      = 400;        // blocks per random page before giving up
  localparam int SETTLE_CYCLES = 10;         // pipeline is two deep; leave margin

  logic                         clk;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic [brpd_pkg::BYTE_W-1:0]  code_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         write_enable;
  logic [brpd_pkg::WADDR_W-1:0] write_address;
  logic [brpd_pkg::BYTE_W-1:0]  byte_value;
  logic [brpd_pkg::BYTE_W-1:0]  repeat_count;
  logic                         page_done;
  logic [brpd_pkg::COUNT_W-1:0] bytes_used;

  int fail_count;
  int pending_results;

  // calm = both sides run back to back; toggled by the stimulus for stretches
  logic calm = 1'b0;

  int requests_sent = 0;
  int results_seen  = 0;
  int pages_seen    = 0;
  int cycle_ctr     = 0;
  int rx_hold       = 0;
  int rx_draw;

  // Opening stream from a fresh page: longest and shortest runs, a mid run,
  // single and double literal blocks, then a literal block left open so the
  // page flush that follows starts in the middle of a block.
  logic [7:0] opening [17] = '{
    8'h80, 8'hFF,                 // run of 130
    8'hFF, 8'h00,                 // run of 3
    8'h81, 8'hA5,                 // run of 129
    8'hC0, 8'h33,                 // run of 66
    8'h00, 8'h5A,                 // one literal
    8'h01, 8'h7F, 8'h80,          // two literals
    8'h04, 8'h01, 8'hFE, 8'h3C    // 5 literals announced, 3 given
  };

  backward_rle_page_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .code_byte     (code_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_enable  (write_enable),
    .write_address (write_address),
    .byte_value    (byte_value),
    .repeat_count  (repeat_count),
    .page_done     (page_done),
    .bytes_used    (bytes_used)
  );

  brpd_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .code_byte       (code_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .write_enable    (write_enable),
    .write_address   (write_address),
    .byte_value      (byte_value),
    .repeat_count    (repeat_count),
    .page_done       (page_done),
    .bytes_used      (bytes_used),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_ctr <= cycle_ctr + 1;
    if (cycle_ctr == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_ctr, pending_results);
      $display("backward_rle_page_decoder_tb: FAIL");
      $finish;
    end
  end

  // Result side: after every taken result, draw a random stall with ready low
  // (none when calm), then hold ready high until the next result goes.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && out_ready) begin
      rx_draw = calm ? 0 : $urandom_range(0, 10);
      rx_hold   <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Page completions as seen on the result channel; the stimulus uses this
  // to know when a page has closed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (page_done) pages_seen <= pages_seen + 1;
    end
  end

  // One request on the input channel. Called at a rising edge; returns at
  // the edge where the byte was taken, with valid still high so a
  // back-to-back request needs no toggle.
  task automatic send_code(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Stop sending and wait for every outstanding result to come back.
  // The first edge lets the checker see the last request.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic send_run(input logic [7:0] hdr);
    send_code(hdr);
    send_code(8'($urandom_range(0, 255)));
  endtask

  task automatic send_literals(input logic [7:0] hdr);
    send_code(hdr);
    repeat (int'(hdr) + 1) send_code(8'($urandom_range(0, 255)));
  endtask

  // Push the decoder to the end of whatever page it is on, one byte at a
  // time with a full drain each, so it is left exactly at a page start.
  // Bytes with bit 7 set are legal in every decode state: as headers they
  // open runs of 127..130.
  task automatic close_page();
    int start;
    start = pages_seen;
    while (pages_seen == start) begin
      send_code(8'h80 | 8'($urandom_range(0, 3)));
      wait_results();
    end
  endtask

  // Mixed block near the page end: runs of any length (clipping at zero),
  // short and long literal blocks (literals past zero), and stray bytes
  // that knock the stream out of block alignment.
  task automatic send_tail_block();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50)      send_run(8'($urandom_range(128, 255)));
    else if (sel < 85) send_literals(8'($urandom_range(0, 15)));
    else if (sel < 95) send_literals(8'($urandom_range(0, 127)));
    else               send_code(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int start_sent;
    int start_pages;
    int fill_runs;
    int blocks;
    bit paused;

    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening on the fresh page
    foreach (opening[i]) send_code(opening[i]);
    close_page();

    // Exact page: 252 runs of 130 leave the top address at 7, then a block
    // of 128 literals writes 8 bytes and runs 120 past zero before closing.
    repeat (252) send_run(8'h80);
    send_literals(8'h7F);

    // Random pages. Most of each page is long runs with random values so
    // the page end is reached quickly; the tail is a random block mix that
    // goes on until the page closes.
    start_sent = requests_sent;
    while (requests_sent - start_sent < RANDOM_TARGET) begin
      start_pages = pages_seen;
      fill_runs   = $urandom_range(250, 252);
      repeat (fill_runs) begin
        send_run(8'h80 | 8'($urandom_range(0, 3)));
        if ($urandom_range(0, 31) == 0) calm <= ~calm;
      end
      blocks = 0;
      while (pages_seen == start_pages && blocks < TAIL_CAP) begin
        send_tail_block();
        if ($urandom_range(0, 15) == 0) calm <= ~calm;
        blocks++;
      end
      // hold off the sender once until the result side has caught up
      if (!paused) begin
        wait_results();
        paused = 1'b1;
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d results over %0d closed pages,",
             requests_sent, results_seen, pages_seen);
    $display("incl. clipped runs, literals past zero and a mid-block page flush");
    if (fail_count == 0 && pending_results == 0) begin
      $display("backward_rle_page_decoder_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending_results);
      $display("backward_rle_page_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/brpd_pkg.sv
src/brpd_in_reg.sv
src/brpd_core.sv
src/brpd_out_reg.sv
src/backward_rle_page_decoder.sv
src/brpd_checker.sv
test/brpd_checker.sv
test/backward_rle_page_decoder_tb.sv
